/* src/fpr_pkg.sv */
// types and constants for the framed packet receiver
// no dependencies; used by framed_packet_receiver
package fpr_pkg;

  // parser phases
  typedef enum logic [3:0] {
    PH_HEAD    = 4'd0,
    PH_LENGTH  = 4'd1,
    PH_ID      = 4'd2,
    PH_PAYLOAD = 4'd3,
    PH_TAIL    = 4'd4,
    PH_CHECK   = 4'd5,
    PH_END1    = 4'd6,
    PH_END2    = 4'd7
  } phase_t;

  // reported event codes
  typedef enum logic [2:0] {
    EV_STORED  = 3'd0,
    EV_LEDSET  = 3'd1,
    EV_LEDGET  = 3'd2,
    EV_TAILERR = 3'd3,
    EV_SUMERR  = 3'd4
  } event_kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_HEAD_BYTE  = 2'd0;
  localparam logic [1:0] REG_TAIL_BYTE  = 2'd1;
  localparam logic [1:0] REG_LED_SET_ID = 2'd2;
  localparam logic [1:0] REG_LED_GET_ID = 2'd3;

  // configuration reset values
  localparam logic [7:0] HEAD_BYTE_RST  = 8'd204;
  localparam logic [7:0] TAIL_BYTE_RST  = 8'd185;
  localparam logic [7:0] LED_SET_ID_RST = 8'd128;
  localparam logic [7:0] LED_GET_ID_RST = 8'd129;

  // one received item
  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] led_state;
  } rx_item_t;

  // one reported item
  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  msg_length;
    logic [7:0]  msg_id;
    logic [7:0]  data_byte;
  } event_item_t;

  // rotate right by one, then add the byte
  function automatic logic [7:0] sum_step(input logic [7:0] sum, input logic [7:0] b);
    sum_step = {sum[0], sum[7:1]} + b;
  endfunction

endpackage

/* src/framed_packet_receiver.sv */
// framed packet receiver: byte parser, checksum and event result register
// depends on fpr_pkg
//
// Takes one received byte per item and parses head, length, ID, payload, tail and
// checksum, then skips two trailer bytes. Each item is handled by the parser state
// machine, and a new item is accepted in every cycle: the only storage between the
// two sides is the event result register, and the input is still taken while a
// finished event waits there, provided that event is taken in the same cycle. At
// most one event comes out per item; it is registered in the cycle after the tail
// byte (tail error) or the checksum byte (all other events) is accepted.
// Configuration writes are taken at any time and take effect in the next cycle.
module framed_packet_receiver (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fpr_pkg::rx_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fpr_pkg::event_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  // configuration registers
  logic [7:0] head_byte, tail_byte, led_set_id, led_get_id;

  // parser state
  fpr_pkg::phase_t phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] frame_id, frame_id_next;
  logic [7:0] last_payload, last_payload_next;
  logic [7:0] led_value, led_value_next;
  logic [7:0] running_checksum, running_checksum_next;
  logic [7:0] payload_count, payload_count_next;

  // result register
  logic                 res_valid;
  fpr_pkg::event_item_t res_data;
  logic                 emit;
  fpr_pkg::event_item_t emit_data;

  logic       in_accept;
  logic [7:0] b;
  logic [7:0] sum_new;
  logic [7:0] count_inc;
  logic [8:0] count_plus_one;

  assign in_ready  = !res_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = res_valid;
  assign out_data  = res_data;

  assign b              = in_data.rx_byte;
  assign sum_new        = fpr_pkg::sum_step(running_checksum, b);
  assign count_inc      = payload_count + 8'd1;
  assign count_plus_one = {1'b0, count_inc} + 9'd1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte  <= fpr_pkg::HEAD_BYTE_RST;
      tail_byte  <= fpr_pkg::TAIL_BYTE_RST;
      led_set_id <= fpr_pkg::LED_SET_ID_RST;
      led_get_id <= fpr_pkg::LED_GET_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpr_pkg::REG_HEAD_BYTE:  head_byte  <= cfg_data;
        fpr_pkg::REG_TAIL_BYTE:  tail_byte  <= cfg_data;
        fpr_pkg::REG_LED_SET_ID: led_set_id <= cfg_data;
        fpr_pkg::REG_LED_GET_ID: led_get_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // next phase and frame fields
  always_comb begin
    phase_next            = phase;
    frame_length_next     = frame_length;
    frame_id_next         = frame_id;
    last_payload_next     = last_payload;
    led_value_next        = led_value;
    running_checksum_next = running_checksum;
    payload_count_next    = payload_count;
    unique case (phase)
      fpr_pkg::PH_LENGTH: begin
        frame_length_next = b;
        phase_next        = fpr_pkg::PH_ID;
      end
      fpr_pkg::PH_ID: begin
        frame_id_next         = b;
        running_checksum_next = sum_new;
        if (b == led_get_id || (b != led_set_id && frame_length <= 8'd1)) begin
          phase_next = fpr_pkg::PH_TAIL;
        end else begin
          phase_next = fpr_pkg::PH_PAYLOAD;
        end
      end
      fpr_pkg::PH_PAYLOAD: begin
        running_checksum_next = sum_new;
        if (frame_id == led_set_id) begin
          led_value_next = b;
          phase_next     = fpr_pkg::PH_TAIL;
        end else begin
          last_payload_next  = b;
          payload_count_next = count_inc;
          if (count_plus_one >= {1'b0, frame_length}) begin
            phase_next = fpr_pkg::PH_TAIL;
          end
        end
      end
      fpr_pkg::PH_TAIL: begin
        phase_next = (b != tail_byte) ? fpr_pkg::PH_HEAD : fpr_pkg::PH_CHECK;
      end
      fpr_pkg::PH_CHECK: begin
        phase_next = (b != running_checksum) ? fpr_pkg::PH_HEAD : fpr_pkg::PH_END1;
      end
      fpr_pkg::PH_END1: phase_next = fpr_pkg::PH_END2;
      fpr_pkg::PH_END2: phase_next = fpr_pkg::PH_HEAD;
      default: begin
        // head hunt, also taken for codes with no meaning
        if (b == head_byte) begin
          frame_length_next     = 8'd0;
          frame_id_next         = 8'd0;
          last_payload_next     = 8'd0;
          led_value_next        = 8'd0;
          running_checksum_next = 8'd0;
          payload_count_next    = 8'd0;
          phase_next            = fpr_pkg::PH_LENGTH;
        end else begin
          phase_next = fpr_pkg::PH_HEAD;
        end
      end
    endcase
  end

  // event produced by this item
  always_comb begin
    emit                 = 1'b0;
    emit_data.event_kind = fpr_pkg::EV_STORED;
    emit_data.msg_length = frame_length;
    emit_data.msg_id     = frame_id;
    emit_data.data_byte  = 8'd0;
    unique case (phase)
      fpr_pkg::PH_TAIL: begin
        if (b != tail_byte) begin
          emit                 = 1'b1;
          emit_data.event_kind = fpr_pkg::EV_TAILERR;
        end
      end
      fpr_pkg::PH_CHECK: begin
        emit = 1'b1;
        if (b != running_checksum) begin
          emit_data.event_kind = fpr_pkg::EV_SUMERR;
        end else if (frame_id == led_get_id) begin
          emit_data.event_kind = fpr_pkg::EV_LEDGET;
          emit_data.data_byte  = in_data.led_state;
        end else if (frame_id == led_set_id) begin
          emit_data.event_kind = fpr_pkg::EV_LEDSET;
          emit_data.data_byte  = led_value;
        end else begin
          emit_data.event_kind = fpr_pkg::EV_STORED;
          emit_data.data_byte  = last_payload;
        end
      end
      default: ;
    endcase
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= fpr_pkg::PH_HEAD;
      frame_length     <= 8'd0;
      frame_id         <= 8'd0;
      last_payload     <= 8'd0;
      led_value        <= 8'd0;
      running_checksum <= 8'd0;
      payload_count    <= 8'd0;
    end else if (in_accept) begin
      phase            <= phase_next;
      frame_length     <= frame_length_next;
      frame_id         <= frame_id_next;
      last_payload     <= last_payload_next;
      led_value        <= led_value_next;
      running_checksum <= running_checksum_next;
      payload_count    <= payload_count_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_accept) begin
      res_valid <= emit;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      res_data <= emit_data;
    end
  end

endmodule
